// ----- hdl/lfpa_pkg.sv -----
// Shared constants for the LIFO free page allocator.
// Holds opcodes, status codes, configuration indexes and fixed field widths.
// Used by the channel interfaces, the address unit and the top level.
package lfpa_pkg;

    // Fixed widths of the byte address and the window base page number.
    localparam int ADDR_BITS = 34;
    localparam int BASE_BITS = 22;
    // Width used for page number compares; holds any page number plus headroom.
    localparam int CMP_BITS  = 36;
    // Width of window base plus link index (base < 2^22, index < 2^15).
    localparam int SUM_BITS  = 23;

    typedef logic [1:0]           opcode_t;
    typedef logic [1:0]           status_t;
    typedef logic [1:0]           cfg_index_t;
    typedef logic [ADDR_BITS-1:0] byte_addr_t;
    typedef logic [BASE_BITS-1:0] base_page_t;
    typedef logic [CMP_BITS-1:0]  page_num_t;

    // Request opcodes.
    localparam opcode_t OP_ALLOC = 2'd0;
    localparam opcode_t OP_FREE  = 2'd1;
    localparam opcode_t OP_INIT  = 2'd2;
    localparam opcode_t OP_NOP   = 2'd3;

    // Response status codes.
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_BAD   = 2'd2;

    // Configuration register indexes.
    localparam cfg_index_t CFG_WINDOW_BASE = 2'd0;
    localparam cfg_index_t CFG_KERNEL_END  = 2'd1;
    localparam cfg_index_t CFG_TOP_ADDR    = 2'd2;

    // Configuration reset values.
    localparam base_page_t RST_WINDOW_BASE = 22'd524288;
    localparam byte_addr_t RST_KERNEL_END  = 34'd2147483648;
    localparam byte_addr_t RST_TOP_ADDR    = 34'd2281701376;

endpackage

// ----- hdl/lfpa_chan_if.sv -----
// Request and response channel interfaces for the free page allocator.
// Each carries valid, ready and the word fields; depends on lfpa_pkg.

interface lfpa_req_if import lfpa_pkg::*; ();
    logic       valid;
    logic       ready;
    opcode_t    opcode;
    byte_addr_t page_address;

    modport source (output valid, output opcode, output page_address, input ready);
    modport sink   (input valid, input opcode, input page_address, output ready);
endinterface

interface lfpa_rsp_if import lfpa_pkg::*; ();
    logic       valid;
    logic       ready;
    byte_addr_t alloc_address;
    status_t    status;

    modport source (output valid, output alloc_address, output status, input ready);
    modport sink   (input valid, input alloc_address, input status, output ready);
endinterface

// ----- hdl/lfpa_link_ram.sv -----
// Link store of the free list: one next link per page.
// Synchronous single write, single read port, registered read.
// Standalone; no package dependency.
module lfpa_link_ram #(
    parameter int DEPTH  = 32768,
    parameter int WIDTH  = 16,
    parameter int AWIDTH = 15
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AWIDTH-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [AWIDTH-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/lfpa_addr_unit.sv -----
// Address arithmetic of the free page allocator.
// Checks free addresses, derives the init page range and forms allocated
// byte addresses. Depends on lfpa_pkg.
module lfpa_addr_unit import lfpa_pkg::*; #(
    parameter int PAGE_BYTES = 4096,
    parameter int PAGE_COUNT = 32768,
    parameter int ADDR_W     = 15
) (
    input  base_page_t        window_base,
    input  byte_addr_t        kernel_end,
    input  byte_addr_t        top_addr,
    input  byte_addr_t        page_address,
    input  logic [ADDR_W-1:0] head_idx,
    output logic              free_ok,
    output logic [ADDR_W-1:0] free_idx,
    output page_num_t         init_first,
    output page_num_t         init_stop,
    output byte_addr_t        alloc_address
);

    localparam int OFS_W = $clog2(PAGE_BYTES);

    page_num_t                     page_num;
    page_num_t                     base_ext;
    page_num_t                     win_end;
    page_num_t                     page_diff;
    logic                          aligned;
    logic [ADDR_BITS:0]            kend_up;
    page_num_t                     first_raw;
    page_num_t                     stop_raw;
    logic [SUM_BITS-1:0]           page_sum;
    logic [SUM_BITS+OFS_W+ADDR_BITS-1:0] addr_wide;

    // Window bounds in page numbers.
    assign base_ext = CMP_BITS'(window_base);
    assign win_end  = base_ext + CMP_BITS'(PAGE_COUNT);

    // Free check: aligned, inside the freeable range and inside the window.
    assign page_num  = CMP_BITS'(page_address[ADDR_BITS-1:OFS_W]);
    assign aligned   = (page_address[OFS_W-1:0] == '0);
    assign page_diff = page_num - base_ext;
    assign free_idx  = page_diff[ADDR_W-1:0];
    assign free_ok   = aligned && (page_address >= kernel_end) &&
                       (page_address < top_addr) &&
                       (page_num >= base_ext) && (page_num < win_end);

    // Init range: kernel end rounded up to a page, clamped to the window.
    assign kend_up   = {1'b0, kernel_end} + (ADDR_BITS+1)'(PAGE_BYTES - 1);
    assign first_raw = CMP_BITS'(kend_up[ADDR_BITS:OFS_W]);
    assign stop_raw  = CMP_BITS'(top_addr[ADDR_BITS-1:OFS_W]);
    assign init_first = (first_raw < base_ext) ? base_ext : first_raw;
    assign init_stop  = (stop_raw > win_end) ? win_end : stop_raw;

    // Allocated byte address: (base + index) * page size, low bits kept.
    assign page_sum      = SUM_BITS'(window_base) + SUM_BITS'(head_idx);
    assign addr_wide     = {{ADDR_BITS{1'b0}}, page_sum, {OFS_W{1'b0}}};
    assign alloc_address = addr_wide[ADDR_BITS-1:0];

endmodule

// ----- hdl/lifo_free_page_allocator.sv -----
// Top level of the LIFO free page allocator: control sequencer, configuration
// registers, head register and response register. Depends on lfpa_pkg,
// lfpa_chan_if, lfpa_link_ram and lfpa_addr_unit.
//
//  Channel  Dir  Fields                         Handshake
//  req      in   opcode, page_address           valid / ready
//  rsp      out  alloc_address, status          valid / ready
//  cfg      in   cfg_index, cfg_data            cfg_we, no back-pressure
//
// Alloc, free and no-op words pass through accept (which, for an alloc, issues
// the link store read of the head) and execute. Init passes through accept,
// execute, init prep, walk (one link store write per cycle) and report.
// Reset empties the free list and loads default configuration; the link
// store is not cleared. A word waits in execute (an init in report) while
// the response register is full; req.ready is high only while the sequencer is idle.
module lifo_free_page_allocator import lfpa_pkg::*; #(
    parameter int PAGE_BYTES = 4096,
    parameter int PAGE_COUNT = 32768
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  cfg_index_t       cfg_index,
    input  byte_addr_t       cfg_data,
    lfpa_req_if.sink         req,
    lfpa_rsp_if.source       rsp
);

    localparam int ADDR_W = $clog2(PAGE_COUNT);
    localparam int LINK_W = $clog2(PAGE_COUNT + 1);
    localparam logic [LINK_W-1:0] EMPTY_MARK = LINK_W'(PAGE_COUNT);

    // Sequencer states.
    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EXEC      = 3'd1;
    localparam logic [2:0] S_INIT_PREP = 3'd2;
    localparam logic [2:0] S_INIT_WALK = 3'd3;
    localparam logic [2:0] S_REPORT    = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [LINK_W-1:0] head_reg, head_next;
    base_page_t        window_base_reg;
    byte_addr_t        kernel_end_reg;
    byte_addr_t        top_addr_reg;
    opcode_t           op_reg;
    byte_addr_t        addr_reg;
    page_num_t         first_reg, first_next;
    page_num_t         stop_reg, stop_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] end_reg, end_next;
    logic              out_valid_reg, out_valid_next;
    byte_addr_t        out_addr_reg, out_addr_next;
    status_t           out_status_reg, out_status_next;

    logic              req_accept;
    logic              can_load;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic              mem_re;
    logic [LINK_W-1:0] mem_rdata;
    logic              free_ok;
    logic [ADDR_W-1:0] free_idx;
    page_num_t         init_first;
    page_num_t         init_stop;
    byte_addr_t        alloc_address;
    page_num_t         first_off;
    page_num_t         stop_off;
    logic [LINK_W-1:0] cur_plus;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_accept = req.valid && req.ready;
    assign can_load   = !out_valid_reg || rsp.ready;

    // The head link is read as an alloc word is taken; nothing writes in that cycle.
    assign mem_re = req_accept && (req.opcode == OP_ALLOC) && (head_reg != EMPTY_MARK);

    lfpa_link_ram #(
        .DEPTH  (PAGE_COUNT),
        .WIDTH  (LINK_W),
        .AWIDTH (ADDR_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (head_reg),
        .re    (mem_re),
        .raddr (head_reg[ADDR_W-1:0]),
        .rdata (mem_rdata)
    );

    lfpa_addr_unit #(
        .PAGE_BYTES (PAGE_BYTES),
        .PAGE_COUNT (PAGE_COUNT),
        .ADDR_W     (ADDR_W)
    ) u_addr_unit (
        .window_base   (window_base_reg),
        .kernel_end    (kernel_end_reg),
        .top_addr      (top_addr_reg),
        .page_address  (addr_reg),
        .head_idx      (head_reg[ADDR_W-1:0]),
        .free_ok       (free_ok),
        .free_idx      (free_idx),
        .init_first    (init_first),
        .init_stop     (init_stop),
        .alloc_address (alloc_address)
    );

    // Init range as link indexes relative to the window base.
    assign first_off = first_reg - CMP_BITS'(window_base_reg);
    assign stop_off  = stop_reg - CMP_BITS'(window_base_reg);
    assign cur_plus  = LINK_W'(cur_reg) + LINK_W'(1);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_base_reg <= RST_WINDOW_BASE;
            kernel_end_reg  <= RST_KERNEL_END;
            top_addr_reg    <= RST_TOP_ADDR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WINDOW_BASE: window_base_reg <= cfg_data[BASE_BITS-1:0];
                CFG_KERNEL_END:  kernel_end_reg  <= cfg_data;
                CFG_TOP_ADDR:    top_addr_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Captured request word.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg   <= req.opcode;
            addr_reg <= req.page_address;
        end
    end

    // Sequencer next state, list updates and response loading.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        first_next      = first_reg;
        stop_next       = stop_reg;
        cur_next        = cur_reg;
        end_next        = end_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = free_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (op_reg == OP_INIT)
                begin
                    first_next = init_first;
                    stop_next  = init_stop;
                    state_next = S_INIT_PREP;
                end
                else if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = '0;
                    out_status_next = ST_OK;
                    case (op_reg)
                        OP_ALLOC:
                        begin
                            if (head_reg == EMPTY_MARK)
                            begin
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                out_addr_next = alloc_address;
                                head_next     = mem_rdata;
                            end
                        end
                        OP_FREE:
                        begin
                            if (free_ok)
                            begin
                                mem_we    = 1'b1;
                                head_next = LINK_W'(free_idx);
                            end
                            else
                            begin
                                out_status_next = ST_BAD;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = S_IDLE;
                end
            end
            S_INIT_PREP:
            begin
                cur_next = first_off[ADDR_W-1:0];
                end_next = stop_off[LINK_W-1:0];
                if (first_reg < stop_reg)
                begin
                    state_next = S_INIT_WALK;
                end
                else
                begin
                    state_next = S_REPORT;
                end
            end
            S_INIT_WALK:
            begin
                // Push one page per cycle in ascending order.
                mem_we    = 1'b1;
                mem_waddr = cur_reg;
                head_next = LINK_W'(cur_reg);
                cur_next  = cur_reg + ADDR_W'(1);
                if (cur_plus == end_reg)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_addr_next   = '0;
                    out_status_next = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= EMPTY_MARK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Walk and response payload registers.
    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        stop_reg       <= stop_next;
        cur_reg        <= cur_next;
        end_reg        <= end_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.alloc_address = out_addr_reg;
    assign rsp.status        = out_status_reg;

endmodule

// ----- tb/tb_lifo_free_page_allocator.sv -----
// Self-checking testbench for the LIFO free page allocator.
// Directed table, then random phases under changing window and range settings.
// Depends on lfpa_pkg, lfpa_chan_if and lifo_free_page_allocator.
`timescale 1ns / 1ps

module tb_lifo_free_page_allocator;
    import lfpa_pkg::*;

    localparam int PG_BYTES = 4096;
    localparam int PG_COUNT = 32768;
    localparam longint unsigned ADDR_MAX = 64'h3_FFFF_FFFF;
    localparam longint unsigned BASE_MAX = 64'd4194303;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 170;
    localparam int SETTLE_CYCLES = 8;
    localparam int INIT_PAGE_LIMIT = 256;
    localparam int HOLD_AT_WORD = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int DIRECTED_ROWS = 32;
    localparam longint TIMEOUT_NS = 64'd60_000_000;

    typedef struct packed {
        byte_addr_t alloc_address;
        status_t    status;
    } page_resp_t;

    typedef struct packed {
        bit         is_reg;
        cfg_index_t reg_index;
        byte_addr_t reg_value;
        opcode_t    opcode;
        byte_addr_t page_address;
        bit         typed;
        page_resp_t expected;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    byte_addr_t cfg_data;

    lfpa_req_if req_ch ();
    lfpa_rsp_if rsp_ch ();

    lifo_free_page_allocator #(
        .PAGE_BYTES (PG_BYTES),
        .PAGE_COUNT (PG_COUNT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the free list and the configuration.
    bit [15:0]       next_link [PG_COUNT];
    int unsigned     free_head;
    longint unsigned win_base;
    longint unsigned kern_end;
    longint unsigned top_addr;

    page_resp_t expected_responses [$];
    byte_addr_t allocated_pages [$];
    stim_row_t  directed_rows [DIRECTED_ROWS];
    int         mismatch_count = 0;
    int         send_calm = 0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    // Page numbers that a free may link and an init pushes: [lo, hi).
    function automatic void freeable_pages(output longint unsigned lo,
                                           output longint unsigned hi);
        lo = (kern_end + PG_BYTES - 1) / PG_BYTES;
        hi = top_addr / PG_BYTES;
        if (lo < win_base)
            lo = win_base;
        if (hi > win_base + PG_COUNT)
            hi = win_base + PG_COUNT;
    endfunction

    function automatic void push_page(longint unsigned index);
        next_link[index] = free_head[15:0];
        free_head = int'(index);
    endfunction

    // Computes the response to one word and updates the shadow free list.
    function automatic page_resp_t predict_page_response(opcode_t op, byte_addr_t addr);
        page_resp_t      resp;
        longint unsigned a;
        longint unsigned page;
        longint unsigned lo;
        longint unsigned hi;
        resp = '0;
        resp.status = ST_OK;
        a = longint'(addr);
        case (op)
            OP_ALLOC:
            begin
                if (free_head < PG_COUNT)
                begin
                    resp.alloc_address = byte_addr_t'((win_base + free_head) * PG_BYTES);
                    free_head = next_link[free_head];
                end
                else
                    resp.status = ST_EMPTY;
            end
            OP_FREE:
            begin
                page = a / PG_BYTES;
                if (a % PG_BYTES == 0 && a >= kern_end && a < top_addr &&
                    page >= win_base && page < win_base + PG_COUNT)
                    push_page(page - win_base);
                else
                    resp.status = ST_BAD;
            end
            OP_INIT:
            begin
                freeable_pages(lo, hi);
                for (longint unsigned p = lo; p < hi; p++)
                    push_page(p - win_base);
            end
            default: ;
        endcase
        return resp;
    endfunction

    function automatic stim_row_t reg_row(cfg_index_t index, byte_addr_t value);
        stim_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.reg_index = index;
        row.reg_value = value;
        return row;
    endfunction

    function automatic stim_row_t word_row(opcode_t op, byte_addr_t addr);
        stim_row_t row;
        row = '0;
        row.opcode = op;
        row.page_address = addr;
        return row;
    endfunction

    function automatic stim_row_t known_row(opcode_t op, byte_addr_t addr,
                                            byte_addr_t exp_addr, status_t exp_status);
        stim_row_t row;
        row = word_row(op, addr);
        row.typed = 1'b1;
        row.expected.alloc_address = exp_addr;
        row.expected.status = exp_status;
        return row;
    endfunction

    // Idle gap length: mostly short, a few long.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Register write on the plain config port; the shadow copy follows it.
    task automatic write_register(cfg_index_t index, byte_addr_t value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        case (index)
            CFG_WINDOW_BASE: win_base = longint'(value[BASE_BITS-1:0]);
            CFG_KERNEL_END:  kern_end = longint'(value);
            CFG_TOP_ADDR:    top_addr = longint'(value);
            default: ;
        endcase
        allocated_pages.delete();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop valid and wait until every response has come back.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one word; valid stays high on return so that a following word
    // can go out back to back.
    task automatic offer_word(opcode_t op, byte_addr_t addr, bit typed, page_resp_t known);
        int         gap;
        page_resp_t predicted;
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 49) == 0)
                send_calm = $urandom_range(50, 200);
            gap = ($urandom_range(0, 2) == 0) ? draw_gap() : 0;
        end
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.page_address <= addr;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = predict_page_response(op, addr);
        if (op == OP_ALLOC && predicted.status == ST_OK)
            allocated_pages.push_back(predicted.alloc_address);
        expected_responses.push_back(typed ? known : predicted);
    endtask

    // One random word: mostly allocs and frees of pages handed out earlier,
    // with some bad, misaligned, boundary and fully random frees mixed in.
    task automatic random_word(output opcode_t op, output byte_addr_t addr);
        int              r;
        int              pick;
        longint unsigned lo;
        longint unsigned hi;
        freeable_pages(lo, hi);
        addr = {2'($urandom_range(0, 3)), $urandom()};
        r = $urandom_range(0, 99);
        if (r < 45)
            op = OP_ALLOC;
        else if (r < 85)
        begin
            op = OP_FREE;
            pick = $urandom_range(0, 99);
            if (pick < 65 && allocated_pages.size() != 0)
            begin
                r = $urandom_range(0, allocated_pages.size() - 1);
                addr = allocated_pages[r];
                allocated_pages.delete(r);
            end
            else if (pick < 75 && lo < hi)
                addr = byte_addr_t'(longint'($urandom_range(int'(lo), int'(hi - 1))) * PG_BYTES);
            else if (pick < 85 && lo < hi)
                addr = byte_addr_t'(longint'($urandom_range(int'(lo), int'(hi - 1))) * PG_BYTES
                                    + $urandom_range(1, PG_BYTES - 1));
            else if (pick < 92)
            begin
                case ($urandom_range(0, 2))
                    0: addr = byte_addr_t'(top_addr);
                    1: addr = byte_addr_t'((lo == 0 ? 0 : lo - 1) * PG_BYTES);
                    default: addr = byte_addr_t'(hi * PG_BYTES);
                endcase
            end
        end
        else if (r < 93)
            op = (hi > lo && hi - lo > INIT_PAGE_LIMIT) ? OP_ALLOC : OP_INIT;
        else
            op = OP_NOP;
    endtask

    // Settings for one random phase; the first three are the extremes.
    task automatic write_phase_config(int phase);
        longint unsigned base;
        longint unsigned kend;
        longint unsigned top;
        longint unsigned kpage;
        case (phase)
            0:
            begin
                base = 0;
                kend = 0;
                top = 100 * PG_BYTES;
            end
            1:
            begin
                // Window at the top of the address space; unaligned kernel end.
                base = BASE_MAX - 120;
                kend = ADDR_MAX - 200 * PG_BYTES;
                top = ADDR_MAX;
            end
            2:
            begin
                // Empty freeable range: every free is rejected.
                base = $urandom_range(0, int'(BASE_MAX));
                kend = ADDR_MAX;
                top = 0;
            end
            default:
            begin
                base = $urandom_range(0, 4_100_000);
                kpage = base + $urandom_range(0, 32760);
                if ($urandom_range(0, 3) == 0)
                    kpage = (kpage >= 60) ? kpage - 60 : 0;
                kend = kpage * PG_BYTES;
                if ($urandom_range(0, 1) == 1)
                    kend += $urandom_range(1, PG_BYTES - 1);
                top = kend + longint'($urandom_range(0, 200)) * PG_BYTES
                      + $urandom_range(0, PG_BYTES - 1);
            end
        endcase
        write_register(CFG_WINDOW_BASE, byte_addr_t'(base));
        write_register(CFG_KERNEL_END, byte_addr_t'(kend));
        write_register(CFG_TOP_ADDR, byte_addr_t'(top));
    endtask

    // Compare one accepted response word with the oldest expectation.
    task automatic check_response();
        page_resp_t want;
        if (expected_responses.size() == 0)
        begin
            mismatch_count++;
            $display("%0t: unexpected response word addr %h status %0d", $time,
                     rsp_ch.alloc_address, rsp_ch.status);
        end
        else
        begin
            want = expected_responses.pop_front();
            if (rsp_ch.alloc_address !== want.alloc_address)
            begin
                mismatch_count++;
                $display("%0t: alloc_address expected %h actual %h", $time,
                         want.alloc_address, rsp_ch.alloc_address);
            end
            if (rsp_ch.status !== want.status)
            begin
                mismatch_count++;
                $display("%0t: status expected %0d actual %0d", $time,
                         want.status, rsp_ch.status);
            end
        end
    endtask

    // Response side: random stalls, calm stretches, and one long hold-off
    // that lets the block back up into its request channel.
    initial
    begin
        int stall_left;
        int calm_left;
        int hold_left;
        int words_seen;
        bit held_once;
        stall_left = 0;
        calm_left = 0;
        hold_left = 0;
        words_seen = 0;
        held_once = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                check_response();
                words_seen++;
            end
            if (!held_once && words_seen == HOLD_AT_WORD)
            begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) == 0)
                    calm_left = $urandom_range(100, 300);
                else if ($urandom_range(0, 3) == 0)
                    stall_left = draw_gap();
            end
        end
    end

    // Request side: reset, directed table, then random phases.
    initial
    begin
        opcode_t    op;
        byte_addr_t addr;
        cfg_we <= 1'b0;
        cfg_index <= CFG_WINDOW_BASE;
        cfg_data <= '0;
        req_ch.valid <= 1'b0;
        req_ch.opcode <= OP_NOP;
        req_ch.page_address <= '0;
        rst_n <= 1'b0;

        win_base = longint'(RST_WINDOW_BASE);
        kern_end = longint'(RST_KERNEL_END);
        top_addr = longint'(RST_TOP_ADDR);
        free_head = PG_COUNT;

        directed_rows = '{
            // Reset settings: empty list, no-op, rejected frees, LIFO order.
            known_row(OP_ALLOC, 34'h0,           34'h0,           ST_EMPTY),
            known_row(OP_NOP,   34'h3_FFFF_FFFF, 34'h0,           ST_OK),
            known_row(OP_FREE,  34'h0,           34'h0,           ST_BAD),
            known_row(OP_FREE,  34'h0_8000_0001, 34'h0,           ST_BAD),
            known_row(OP_FREE,  34'h0_8800_0000, 34'h0,           ST_BAD),
            known_row(OP_FREE,  34'h3_FFFF_FFFF, 34'h0,           ST_BAD),
            known_row(OP_FREE,  34'h0_8000_0000, 34'h0,           ST_OK),
            known_row(OP_FREE,  34'h0_87FF_F000, 34'h0,           ST_OK),
            known_row(OP_ALLOC, 34'h0,           34'h0_87FF_F000, ST_OK),
            known_row(OP_ALLOC, 34'h0,           34'h0_8000_0000, ST_OK),
            known_row(OP_ALLOC, 34'h0,           34'h0,           ST_EMPTY),
            // Window at zero, unaligned kernel end: init pushes pages 2 to 4.
            reg_row(CFG_WINDOW_BASE, 34'd0),
            reg_row(CFG_KERNEL_END,  34'd4097),
            reg_row(CFG_TOP_ADDR,    34'd20580),
            known_row(OP_INIT,  34'h0,           34'h0,           ST_OK),
            known_row(OP_ALLOC, 34'h0,           34'h0_0000_4000, ST_OK),
            known_row(OP_ALLOC, 34'h0,           34'h0_0000_3000, ST_OK),
            known_row(OP_ALLOC, 34'h0,           34'h0_0000_2000, ST_OK),
            known_row(OP_ALLOC, 34'h0,           34'h0,           ST_EMPTY),
            // Repeated init pushes the same pages onto the list again.
            known_row(OP_INIT,  34'h0,           34'h0,           ST_OK),
            known_row(OP_INIT,  34'h0,           34'h0,           ST_OK),
            word_row(OP_ALLOC,  34'h0),
            // Window base at its maximum, full address range.
            reg_row(CFG_WINDOW_BASE, 34'd4194303),
            reg_row(CFG_KERNEL_END,  34'd0),
            reg_row(CFG_TOP_ADDR,    34'h3_FFFF_FFFF),
            known_row(OP_FREE,  34'h3_FFFF_F000, 34'h0,           ST_OK),
            known_row(OP_FREE,  34'h0_0000_1000, 34'h0,           ST_BAD),
            known_row(OP_INIT,  34'h0,           34'h0,           ST_OK),
            known_row(OP_ALLOC, 34'h0,           34'h3_FFFF_F000, ST_OK),
            // Older pages now map past the top of the address space.
            word_row(OP_ALLOC,  34'h0),
            // Double free of the same page.
            known_row(OP_FREE,  34'h3_FFFF_F000, 34'h0,           ST_OK),
            known_row(OP_FREE,  34'h3_FFFF_F000, 34'h0,           ST_OK)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg)
            begin
                settle_block();
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
                offer_word(directed_rows[i].opcode, directed_rows[i].page_address,
                           directed_rows[i].typed, directed_rows[i].expected);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            write_phase_config(phase);
            repeat (WORDS_PER_PHASE)
            begin
                random_word(op, addr);
                offer_word(op, addr, 1'b0, '0);
            end
        end

        settle_block();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/lfpa_pkg.sv
hdl/lfpa_chan_if.sv
hdl/lfpa_link_ram.sv
hdl/lfpa_addr_unit.sv
hdl/lifo_free_page_allocator.sv
tb/tb_lifo_free_page_allocator.sv
